// File: rtl/dmx4rx_pkg.sv
// Shared types and constants for the four-channel DMX512 receiver.
package dmx4rx_pkg;

    localparam int unsigned NUM_CH    = 4;
    localparam int unsigned SLOT_W    = 10;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CNT_W     = 2;
    localparam int unsigned CFG_IDX_W = 4;

    localparam logic [BYTE_W-1:0] DMX_NULL_SC        = 8'h00;
    localparam logic [SLOT_W-1:0] SLOT_MAX           = 10'd1023;
    localparam logic [CNT_W-1:0]  GOOD_FRAMES_NEEDED = 2'd3;

    typedef enum logic [1:0] {
        PH_WAIT_BREAK = 2'd0,
        PH_WAIT_START = 2'd1,
        PH_RECEIVING  = 2'd2
    } t_phase;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_A = 4'd0,
        CFG_SLOT_B = 4'd1,
        CFG_SLOT_C = 4'd2,
        CFG_SLOT_D = 4'd3
    } t_cfg_idx;

    typedef logic [NUM_CH-1:0][SLOT_W-1:0] t_slot_addr;

    typedef struct packed {
        logic              framing_error;
        logic              overrun_error;
        logic [BYTE_W-1:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic                          overrun_seen;
        logic                          frames_valid;
        logic [NUM_CH-1:0][BYTE_W-1:0] levels;
    } t_result;

endpackage

// File: rtl/dmx4rx_core.sv
// Frame tracking state and slot capture for the DMX512 receiver.
module dmx4rx_core
    import dmx4rx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_item      i_item,
    input  t_slot_addr i_addr,
    output t_result    o_result
);

    t_phase                        r_phase, n_phase;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    logic                          r_ready, n_ready;
    logic                          r_sticky, n_sticky;
    logic [NUM_CH-1:0][BYTE_W-1:0] r_levels, n_levels;
    logic [NUM_CH-1:0]             w_hit;
    logic                          w_end;
    logic                          w_start_ok;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            w_hit[ch] = (r_slot == i_addr[ch]);
        end
    end

    assign w_end      = w_hit[NUM_CH-1];
    assign w_start_ok = (i_item.rx_byte == DMX_NULL_SC);

    always_comb begin
        n_phase = r_phase;
        if (i_item.overrun_error) begin
            n_phase = PH_WAIT_BREAK;
        end else if (i_item.framing_error) begin
            n_phase = PH_WAIT_START;
        end else begin
            unique case (r_phase)
                PH_WAIT_START: n_phase = w_start_ok ? PH_RECEIVING : PH_WAIT_BREAK;
                PH_RECEIVING: begin
                    if (w_end) n_phase = PH_WAIT_BREAK;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_comb begin
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_ready  = r_ready;
        n_sticky = r_sticky;
        n_levels = r_levels;
        if (i_item.overrun_error) begin
            n_sticky = 1'b1;
            n_slot   = '0;
            n_cnt    = '0;
            n_ready  = 1'b0;
        end else if (i_item.framing_error) begin
            n_slot = '0;
        end else begin
            unique case (r_phase)
                PH_WAIT_START: begin
                    if (w_start_ok) begin
                        n_slot = SLOT_W'(1);
                    end else begin
                        n_cnt   = '0;
                        n_ready = 1'b0;
                    end
                end
                PH_RECEIVING: begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        if (w_hit[ch]) n_levels[ch] = i_item.rx_byte;
                    end
                    if (w_end) begin
                        if (r_cnt != GOOD_FRAMES_NEEDED) n_cnt = r_cnt + CNT_W'(1);
                        if (n_cnt == GOOD_FRAMES_NEEDED) n_ready = 1'b1;
                    end
                    if (r_slot != SLOT_MAX) n_slot = r_slot + SLOT_W'(1);
                end
                default: n_slot = r_slot;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT_BREAK;
            r_slot   <= '0;
            r_cnt    <= '0;
            r_ready  <= 1'b0;
            r_sticky <= 1'b0;
            r_levels <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_slot   <= n_slot;
            r_cnt    <= n_cnt;
            r_ready  <= n_ready;
            r_sticky <= n_sticky;
            r_levels <= n_levels;
        end
    end

    assign o_result.levels       = n_levels;
    assign o_result.frames_valid = n_ready;
    assign o_result.overrun_seen = n_sticky;

endmodule

// File: rtl/dmx512_four_channel_receiver.sv
// Top level of the four-channel DMX512 receiver: beat registers, config and checks.
//
//  channel   direction  handshake                   payload
//  s_axis    in         s_axis_tvalid/tready        tdata: rx_byte; tuser: overrun, framing
//  m_axis    out        m_axis_tvalid/tready        tdata: levels a..d; tuser: ready, overrun
//  cfg       in         i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
// One beat per cycle while the result register is not stalled; each result passes
// the input register, then update logic into the result register.
// Reset is synchronous and active low; it clears frame state and levels and
// loads slot addresses 1..4. A stalled result holds while one more input
// beat waits in the input register.
module dmx512_four_channel_receiver
    import dmx4rx_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [7:0]              s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]              s_axis_tuser,   // [0] overrun_error, [1] framing_error
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [31:0]             m_axis_tdata,   // [7:0] a, [15:8] b, [23:16] c, [31:24] d
    output logic [1:0]              m_axis_tuser,   // [0] frames_valid, [1] overrun_seen
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [SLOT_W-1:0]       i_cfg_data
);

    logic       r_in_valid;
    t_item      r_in_item;
    logic       r_out_valid;
    t_result    r_out_data;
    t_result    w_result;
    t_slot_addr r_addr;
    logic       w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.rx_byte       <= s_axis_tdata;
            r_in_item.overrun_error <= s_axis_tuser[0];
            r_in_item.framing_error <= s_axis_tuser[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr[0] <= SLOT_W'(1);
            r_addr[1] <= SLOT_W'(2);
            r_addr[2] <= SLOT_W'(3);
            r_addr[3] <= SLOT_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SLOT_A: r_addr[0] <= i_cfg_data;
                CFG_SLOT_B: r_addr[1] <= i_cfg_data;
                CFG_SLOT_C: r_addr[2] <= i_cfg_data;
                CFG_SLOT_D: r_addr[3] <= i_cfg_data;
                default:    r_addr    <= r_addr;
            endcase
        end
    end

    dmx4rx_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_in_item),
        .i_addr   (r_addr),
        .o_result (w_result)
    );

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data.levels;
    assign m_axis_tuser[0] = r_out_data.frames_valid;
    assign m_axis_tuser[1] = r_out_data.overrun_seen;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid)
        else $error("input beat dropped while result stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out_data))
        else $error("result lost or changed while stalled");

    a_overrun_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in_item.overrun_error |=> r_out_data.overrun_seen && !r_out_data.frames_valid)
        else $error("overrun did not set sticky flag and clear ready");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_out_valid && r_out_data.overrun_seen |=> r_out_data.overrun_seen)
        else $error("sticky overrun flag cleared");

endmodule
